// ===== src/rws_pkg.sv =====
// Shared types and constants for the roulette wheel selector.
// Item and result payloads, controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package rws_pkg;

    localparam int POP_MAX_DEF = 256;
    localparam int SUM_W       = 40;
    localparam int FIT_W       = 32;
    localparam int FRAC_W      = 16;
    localparam int INDEX_W     = 8;

    // Opcodes; the fourth code does nothing and returns an ok result
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_SELECT = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [FIT_W-1:0]  fitness;
        logic [FRAC_W-1:0] random_fraction;
    } rws_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] selected_index;
        logic [1:0]         status;
    } rws_result_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;    // latch the accepted item
        logic exec;    // clear, append, or write a short result
        logic mul;     // form the two partial products of the draw
        logic init;    // form the target and open the search window
        logic rd;      // read the entry at the window midpoint
        logic cmp;     // narrow the window against the read entry
        logic finish;  // write the search result
    } rws_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] op;
        logic       empty;
        logic       search_end;
    } rws_stat_t;

endpackage

`default_nettype wire

// ===== src/rws_ctrl.sv =====
// Controller state machine for the roulette wheel selector.
// Sequences the datapath through execute, multiply and binary search.
// Depends on rws_pkg.
`default_nettype none

module rws_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    output logic                    done,
    output rws_pkg::rws_cmd_t       cmd,
    input  wire rws_pkg::rws_stat_t stat
);
    import rws_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_INIT,
        S_RD,
        S_CMP
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.op == OP_SELECT && !stat.empty)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = S_RD;
            end
            S_RD:
            begin
                // window closed: the lower bound is the answer
                if (stat.search_end)
                begin
                    cmd.finish = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = S_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

`ifndef ASSERT_OFF
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && state_reg == S_IDLE) |=> (state_reg == S_EXEC))
        else $error("accepted transfer did not reach execute");

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while still busy");
`endif

endmodule

`default_nettype wire

// ===== src/rws_dp.sv =====
// Datapath for the roulette wheel selector: cumulative sum memory,
// running total, draw scaling and binary search window.
// Depends on rws_pkg.
`default_nettype none

module rws_dp #(
    parameter int POP_MAX = rws_pkg::POP_MAX_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rws_pkg::rws_item_t item,
    input  wire rws_pkg::rws_cmd_t  cmd,
    output rws_pkg::rws_stat_t      stat,
    output rws_pkg::rws_result_t    result
);
    import rws_pkg::*;

    localparam int IDX_W  = $clog2(POP_MAX);
    localparam int CNT_W  = $clog2(POP_MAX + 1);
    localparam int HALF_W = SUM_W / 2;
    localparam int PROD_W = FRAC_W + HALF_W;
    localparam int WIDE_W = FRAC_W + SUM_W;

    logic [SUM_W-1:0]  mem [POP_MAX];

    logic [1:0]        op_reg;
    logic [FIT_W-1:0]  fit_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  total_reg;
    logic [PROD_W-1:0] prod_lo_reg;
    logic [PROD_W-1:0] prod_hi_reg;
    logic [SUM_W-1:0]  target_reg;
    logic [CNT_W-1:0]  lo_reg;
    logic [CNT_W-1:0]  hi_reg;
    logic [CNT_W-1:0]  mid_reg;
    logic [SUM_W-1:0]  rdata_reg;
    rws_result_t       result_reg;

    logic              empty;
    logic              full;
    logic              do_append;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_sat;
    logic [CNT_W:0]    mid_sum;
    logic [CNT_W-1:0]  mid;
    logic [WIDE_W-1:0] scaled;
    logic [CNT_W-1:0]  pick;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(POP_MAX));
    assign do_append = cmd.exec && (op_reg == OP_APPEND) && !full;

    // Saturate the running total at the top of the sum range
    assign sum_wide = {1'b0, total_reg} + {(SUM_W + 1 - FIT_W)'(0), fit_reg};
    assign sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_W:1];

    assign scaled = {prod_hi_reg, HALF_W'(0)} + {HALF_W'(0), prod_lo_reg};

    // Clamp to the last stored entry when nothing exceeds the target
    assign pick = (lo_reg >= count_reg) ? (count_reg - CNT_W'(1)) : lo_reg;

    always_ff @(posedge clk)
    begin
        if (do_append)
        begin
            mem[count_reg[IDX_W-1:0]] <= sum_sat;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[mid[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
        end
        else if (cmd.exec && op_reg == OP_CLEAR)
        begin
            count_reg <= '0;
            total_reg <= '0;
        end
        else if (do_append)
        begin
            count_reg <= count_reg + CNT_W'(1);
            total_reg <= sum_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= item.opcode;
            fit_reg  <= item.fitness;
            frac_reg <= item.random_fraction;
        end
        if (cmd.mul)
        begin
            prod_lo_reg <= frac_reg * total_reg[HALF_W-1:0];
            prod_hi_reg <= frac_reg * total_reg[SUM_W-1:HALF_W];
        end
        if (cmd.init)
        begin
            target_reg <= scaled[WIDE_W-1:FRAC_W];
            lo_reg     <= '0;
            hi_reg     <= count_reg;
        end
        if (cmd.rd)
        begin
            mid_reg <= mid;
        end
        if (cmd.cmp)
        begin
            if (rdata_reg > target_reg)
            begin
                hi_reg <= mid_reg;
            end
            else
            begin
                lo_reg <= mid_reg + CNT_W'(1);
            end
        end
        if (cmd.exec)
        begin
            result_reg.selected_index <= '0;
            if (op_reg == OP_APPEND && full)
            begin
                result_reg.status <= ST_FULL;
            end
            else if (op_reg == OP_SELECT && empty)
            begin
                result_reg.status <= ST_EMPTY;
            end
            else
            begin
                result_reg.status <= ST_OK;
            end
        end
        else if (cmd.finish)
        begin
            result_reg.selected_index <= INDEX_W'(pick);
            result_reg.status         <= ST_OK;
        end
    end

    assign stat.op         = op_reg;
    assign stat.empty      = empty;
    assign stat.search_end = (lo_reg >= hi_reg);

    assign result = result_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(POP_MAX))
        else $error("entry count beyond table depth");

    a_read_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cmp |-> (mid_reg < count_reg && hi_reg <= count_reg))
        else $error("search read outside the stored entries");

    a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
        do_append |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("append did not advance the entry count");
`endif

endmodule

`default_nettype wire

// ===== src/roulette_wheel_selector_unit.sv =====
// Roulette wheel selector: top level joining the controller and datapath.
// Depends on rws_pkg, rws_ctrl and rws_dp.
//
// Usage:
//   Command channel: an item (opcode, fitness, random_fraction) is taken
//   at a rising edge with start high and busy low. Result channel: done is
//   high for exactly one cycle with selected_index and status on result;
//   the receiver takes it at the end of that cycle and cannot hold it off.
//   Latency: clear, append and any select on an empty table raise done
//   1 cycle after the transfer edge, with busy low again in that cycle, so
//   one such item every 2 cycles. A select on n entries raises done
//   4 + 2k cycles after the transfer edge, so one select every 5 + 2k
//   cycles, k being the binary search steps (at most ceil(log2(n + 1)),
//   9 for a full 256 entry table); each step is one read of the single
//   port sum memory and one compare.
//   The draw is scaled by two 16 x 20 partial products in one cycle.
//   Reset clears the entry count and running total; the memory is not
//   cleared, entries above the count are never read.
//   No stall can arise on the result side.
`default_nettype none

module roulette_wheel_selector_unit #(
    parameter int POP_MAX = rws_pkg::POP_MAX_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire rws_pkg::rws_item_t item,
    output logic                    done,
    output rws_pkg::rws_result_t    result
);
    import rws_pkg::*;

    rws_cmd_t  cmd;
    rws_stat_t stat;

    rws_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    rws_dp #(
        .POP_MAX (POP_MAX)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule

`default_nettype wire

// ===== test/tb_roulette_wheel_selector_unit.sv =====
// Testbench for roulette_wheel_selector_unit: directed and random clear, append and
// select traffic, checked against an in-bench model of the cumulative fitness table.
// Depends on rws_pkg and the selector RTL.
`timescale 1ns / 1ps

module tb_roulette_wheel_selector_unit;

    import rws_pkg::*;

    localparam int          WHEEL_DEPTH = POP_MAX_DEF;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          RANDOM_OPS  = 1450;
    localparam logic [1:0]  OP_NOP      = 2'd3;
    localparam logic [15:0] FRAC_MAX    = 16'hFFFF;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    rws_item_t   item  = '0;
    logic        busy;
    logic        done;
    rws_result_t result;

    // Model state: cumulative sums, entry count and running total
    logic [SUM_W-1:0] wheel_sum [0:WHEEL_DEPTH-1];
    int unsigned      wheel_count;
    logic [SUM_W-1:0] wheel_total;

    rws_item_t   wheel_ops[$];
    rws_result_t predicted_picks[$];

    int  n_transfers;
    int  total_items;
    int  n_hits;
    int  n_empty;
    int  n_full;
    int  n_errors;
    int  cycle_count;
    bit  line_taken;
    int  gap_left;
    int  burst_left;

    roulette_wheel_selector_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Apply one transfer to the model and return the result it must produce
    function automatic rws_result_t spin_wheel(rws_item_t it);
        rws_result_t      res;
        logic [SUM_W:0]   sum;
        logic [55:0]      prod;
        logic [SUM_W-1:0] target;
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      mid;
        res = '0;
        res.status = ST_OK;
        case (it.opcode)
            OP_CLEAR:
            begin
                wheel_count = 0;
                wheel_total = '0;
            end
            OP_APPEND:
            begin
                if (wheel_count >= WHEEL_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    sum = {1'b0, wheel_total} + (SUM_W+1)'(it.fitness);
                    // saturate the total rather than wrap
                    if (sum[SUM_W])
                        sum = {1'b0, {SUM_W{1'b1}}};
                    wheel_total = sum[SUM_W-1:0];
                    wheel_sum[wheel_count] = wheel_total;
                    wheel_count++;
                end
            end
            OP_SELECT:
            begin
                if (wheel_count == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    prod   = 56'(it.random_fraction) * 56'(wheel_total);
                    target = prod[55:16];
                    lo = 0;
                    hi = wheel_count;
                    while (lo < hi)
                    begin
                        mid = lo + (hi - lo) / 2;
                        if (wheel_sum[mid] > target)
                            hi = mid;
                        else
                            lo = mid + 1;
                    end
                    // clamp to the last entry when nothing exceeds the target
                    if (lo >= wheel_count)
                        lo = wheel_count - 1;
                    res.selected_index = INDEX_W'(lo);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void queue_op(logic [1:0] op, logic [FIT_W-1:0] fit,
                                     logic [FRAC_W-1:0] frac);
        rws_item_t it;
        it.opcode          = op;
        it.fitness         = fit;
        it.random_fraction = frac;
        wheel_ops = {wheel_ops, it};
    endfunction

    function automatic logic [FIT_W-1:0] pick_fitness(int style);
        int sel;
        sel = (style == 3) ? $urandom_range(0, 2) : style;
        case (sel)
            0:       return '0;
            1:       return FIT_W'($urandom_range(0, 100));
            default: return ($urandom_range(0, 7) == 0) ? {FIT_W{1'b1}} : FIT_W'($urandom());
        endcase
    endfunction

    function automatic logic [FRAC_W-1:0] pick_fraction();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return FRAC_MAX;
            default: return FRAC_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        n_errors++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Monitor: record transfers into the model, check each result against the oldest prediction
    always @(posedge clk)
    begin
        rws_result_t want;
        if (!rst_n)
            line_taken = 1'b0;
        else
        begin
            line_taken = start && !busy;
            if (line_taken)
            begin
                want = spin_wheel(item);
                predicted_picks = {predicted_picks, want};
                n_transfers++;
                if (item.opcode == OP_SELECT && want.status == ST_OK)
                    n_hits++;
                if (want.status == ST_EMPTY)
                    n_empty++;
                if (want.status == ST_FULL)
                    n_full++;
            end
            if (done)
            begin
                if (predicted_picks.size() == 0)
                begin
                    n_errors++;
                    $display("[%0t] result strobe with nothing outstanding", $realtime);
                end
                else
                begin
                    want = predicted_picks.pop_front();
                    if (result.selected_index !== want.selected_index)
                        flag_mismatch("selected_index", result.selected_index,
                                      want.selected_index);
                    if (result.status !== want.status)
                        flag_mismatch("status", result.status, want.status);
                end
            end
        end
    end

    // Driver: offer the next item once the previous transfer has gone, after a random gap
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || line_taken)
        begin
            if (gap_left != 0)
            begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end
            else if (wheel_ops.size() != 0)
            begin
                item  <= wheel_ops.pop_front();
                start <= 1'b1;
                if (burst_left != 0)
                begin
                    burst_left = burst_left - 1;
                    gap_left   = 0;
                end
                else
                begin
                    gap_left = $urandom_range(0, 7);
                    if ($urandom_range(0, 15) == 0)
                        burst_left = $urandom_range(10, 40);
                end
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, predicted_picks.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int ops;
        int n_app;
        int n_sel;
        int style;
        wheel_count = 0;
        wheel_total = '0;

        // Directed: empty table, unused opcode, all-zero fitness, extremes of both fields
        queue_op(OP_SELECT, '0, FRAC_MAX);
        queue_op(OP_NOP, {FIT_W{1'b1}}, FRAC_MAX);
        queue_op(OP_APPEND, '0, '0);
        queue_op(OP_APPEND, '0, '0);
        queue_op(OP_APPEND, '0, FRAC_MAX);
        queue_op(OP_SELECT, '0, '0);
        queue_op(OP_SELECT, {FIT_W{1'b1}}, FRAC_MAX);
        queue_op(OP_CLEAR, {FIT_W{1'b1}}, FRAC_MAX);
        queue_op(OP_APPEND, {FIT_W{1'b1}}, '0);
        queue_op(OP_APPEND, 32'd1, '0);
        queue_op(OP_APPEND, {FIT_W{1'b1}}, '0);
        queue_op(OP_SELECT, '0, '0);
        queue_op(OP_SELECT, '0, 16'h8000);
        queue_op(OP_SELECT, '0, FRAC_MAX);
        queue_op(OP_CLEAR, '0, '0);
        queue_op(OP_SELECT, '0, 16'h1234);
        queue_op(OP_APPEND, 32'd5, '0);
        queue_op(OP_SELECT, '0, FRAC_MAX);
        queue_op(OP_NOP, '0, '0);
        ops = 19;

        // Fill the table past its depth once so that appends get dropped
        queue_op(OP_CLEAR, '0, '0);
        for (int i = 0; i < WHEEL_DEPTH + 4; i++)
            queue_op(OP_APPEND, pick_fitness(3), '0);
        for (int i = 0; i < 8; i++)
            queue_op(OP_SELECT, '0, pick_fraction());
        ops += WHEEL_DEPTH + 13;

        while (ops < RANDOM_OPS)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                // well-formed round: clear (in most rounds), a run of appends, then draws
                if ($urandom_range(0, 4) != 0)
                begin
                    queue_op(OP_CLEAR, FIT_W'($urandom()), pick_fraction());
                    ops++;
                end
                style = $urandom_range(0, 3);
                n_app = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 64)
                                                    : $urandom_range(1, 16);
                n_sel = $urandom_range(1, 8);
                for (int i = 0; i < n_app; i++)
                    queue_op(OP_APPEND, pick_fitness(style), FRAC_W'($urandom()));
                for (int i = 0; i < n_sel; i++)
                    queue_op(OP_SELECT, FIT_W'($urandom()), pick_fraction());
                ops += n_app + n_sel;
            end
            else
            begin
                // noise: any opcode, any fields
                n_app = $urandom_range(1, 4);
                for (int i = 0; i < n_app; i++)
                begin
                    queue_op(2'($urandom_range(0, 3)), FIT_W'($urandom()),
                             FRAC_W'($urandom()));
                    ops++;
                end
            end
        end
        total_items = wheel_ops.size();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (n_transfers < total_items)
            @(posedge clk);
        while (predicted_picks.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Ran %0d transfers: %0d draws answered, %0d draws on an empty table,",
                 n_transfers, n_hits, n_empty);
        $display("%0d appends refused on a full table, %0d mismatches", n_full, n_errors);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
